@@ rtl/lip_com_zmp_retarget_top_defines.svh @@
// ----------------------------------------------------------------------------
// lip_com_zmp_retarget_top_defines.svh
// Assertion macros shared by the retargeting RTL.
// ----------------------------------------------------------------------------
`ifndef LIP_COM_ZMP_RETARGET_TOP_DEFINES_SVH
`define LIP_COM_ZMP_RETARGET_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LCZ_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion label failed");
`define LCZ_ASSERT_DLY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion label failed");
`else
`define LCZ_ASSERT(label, ante, cons)
`define LCZ_ASSERT_DLY(label, ante, n, cons)
`endif

`endif

@@ rtl/lcz_pkg.sv @@
// ----------------------------------------------------------------------------
// lcz_pkg
// Types, constants and helpers for the LIP CoM/ZMP retargeting pipeline.
// ----------------------------------------------------------------------------
package lcz_pkg;

  localparam logic [19:0] GRAV_Q16 = 20'd642689;
  localparam logic [17:0] HC_MIN   = 18'd6554;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned HEIGHT_W = 18;
  localparam int unsigned DAMP_W   = 25;
  localparam int unsigned CFG_W    = 25;
  localparam int unsigned K_W      = 24;
  localparam int unsigned K2_W     = 31;

  // restoring divider: quotient bits resolved per stage
  localparam int unsigned DIV_SPS   = 4;
  localparam int unsigned K_NUM_W   = 36;
  localparam int unsigned Q_NUM_W   = 64;
  localparam int unsigned K_DIV_LAT = (K_NUM_W + DIV_SPS - 1) / DIV_SPS;
  localparam int unsigned Q_DIV_LAT = (Q_NUM_W + DIV_SPS - 1) / DIV_SPS;
  localparam int unsigned AXIS_LAT  = 3 + Q_DIV_LAT + 5;

  typedef enum logic [1:0] {
    CFG_PERIOD = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DAMP_X = 2'd2,
    CFG_DAMP_Y = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] vdes;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } axis_in_t;

  typedef struct packed {
    logic signed [31:0] pos_stable;
    logic signed [31:0] vel_stable;
    logic signed [31:0] zmp;
    logic signed [31:0] zmp_actual;
  } axis_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/lcz_div.sv @@
// ----------------------------------------------------------------------------
// lcz_div
// Pipelined unsigned restoring divider, SPS quotient bits per stage, with a
// sideband that travels alongside.
// ----------------------------------------------------------------------------
module lcz_div #(
  parameter int unsigned NUM_W  = 36,
  parameter int unsigned DEN_W  = 18,
  parameter int unsigned SIDE_W = 1,
  parameter int unsigned SPS    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int unsigned STAGES = (NUM_W + SPS - 1) / SPS;
  localparam int unsigned ALL_W  = STAGES * SPS;

  logic              valid_r [STAGES];
  logic [ALL_W-1:0]  num_r   [STAGES];
  logic [ALL_W-1:0]  quot_r  [STAGES];
  logic [DEN_W-1:0]  rem_r   [STAGES];
  logic [DEN_W-1:0]  den_r   [STAGES];
  logic [SIDE_W-1:0] side_r  [STAGES];

  logic [ALL_W-1:0]  num_nxt  [STAGES];
  logic [ALL_W-1:0]  quot_nxt [STAGES];
  logic [DEN_W-1:0]  rem_nxt  [STAGES];

  logic              valid_p [STAGES];
  logic [ALL_W-1:0]  num_p   [STAGES];
  logic [ALL_W-1:0]  quot_p  [STAGES];
  logic [DEN_W-1:0]  rem_p   [STAGES];
  logic [DEN_W-1:0]  den_p   [STAGES];
  logic [SIDE_W-1:0] side_p  [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign valid_p[j] = in_valid;
      assign num_p[j]   = ALL_W'(in_num);
      assign quot_p[j]  = '0;
      assign rem_p[j]   = '0;
      assign den_p[j]   = in_den;
      assign side_p[j]  = in_side;
    end else begin : g_next
      assign valid_p[j] = valid_r[j-1];
      assign num_p[j]   = num_r[j-1];
      assign quot_p[j]  = quot_r[j-1];
      assign rem_p[j]   = rem_r[j-1];
      assign den_p[j]   = den_r[j-1];
      assign side_p[j]  = side_r[j-1];
    end

    always_comb begin
      logic [DEN_W-1:0] rem_v;
      logic [ALL_W-1:0] num_v;
      logic [ALL_W-1:0] quot_v;
      logic [DEN_W:0]   trial;
      rem_v  = rem_p[j];
      num_v  = num_p[j];
      quot_v = quot_p[j];
      for (int s = 0; s < SPS; s++) begin
        trial = {rem_v, num_v[ALL_W-1]};
        num_v = {num_v[ALL_W-2:0], 1'b0};
        if (trial >= {1'b0, den_p[j]}) begin
          rem_v  = DEN_W'(trial - {1'b0, den_p[j]});
          quot_v = {quot_v[ALL_W-2:0], 1'b1};
        end else begin
          rem_v  = trial[DEN_W-1:0];
          quot_v = {quot_v[ALL_W-2:0], 1'b0};
        end
      end
      rem_nxt[j]  = rem_v;
      num_nxt[j]  = num_v;
      quot_nxt[j] = quot_v;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else begin
        valid_r[j] <= valid_p[j];
      end
    end

    always_ff @(posedge clk) begin
      num_r[j]  <= num_nxt[j];
      quot_r[j] <= quot_nxt[j];
      rem_r[j]  <= rem_nxt[j];
      den_r[j]  <= den_p[j];
      side_r[j] <= side_p[j];
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_quot  = quot_r[STAGES-1][NUM_W-1:0];
  assign out_side  = side_r[STAGES-1];

endmodule

@@ rtl/lcz_axis.sv @@
// ----------------------------------------------------------------------------
// lcz_axis
// One axis: gradient and Hessian, bounded QP solve, stabilized velocity,
// position and measured-CoM ZMP.
// ----------------------------------------------------------------------------
`include "lip_com_zmp_retarget_top_defines.svh"

module lcz_axis (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [lcz_pkg::K_W-1:0]            in_k,
  input  lcz_pkg::axis_in_t                  in_data,
  input  logic [lcz_pkg::DAMP_W-1:0]         lambda,
  input  logic [lcz_pkg::PERIOD_W-1:0]       period,
  input  logic [lcz_pkg::HEIGHT_W-1:0]       height,
  output logic                               out_valid,
  output lcz_pkg::axis_out_t                 out_data
);
  import lcz_pkg::*;

  localparam int unsigned SIDE_W = $bits(axis_in_t) + K_W + 2;

  // stage 1
  logic               a1_valid_r;
  axis_in_t           a1_in_r;
  logic [K_W-1:0]     a1_k_r;
  logic [K2_W-1:0]    a1_k2_r;
  logic signed [32:0] a1_d_r;
  logic signed [50:0] a1_hacc_r;
  logic [47:0]        k_sq;
  logic signed [50:0] hacc_nxt;

  assign k_sq     = {24'b0, in_k} * {24'b0, in_k};
  assign hacc_nxt = $signed({1'b0, height}) * in_data.acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_valid_r <= 1'b0;
    end else begin
      a1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a1_in_r   <= in_data;
    a1_k_r    <= in_k;
    a1_k2_r   <= k_sq[46:16];
    a1_d_r    <= {in_data.vdes[31], in_data.vdes} - {in_data.vel[31], in_data.vel};
    a1_hacc_r <= hacc_nxt;
  end

  // stage 2
  logic               a2_valid_r;
  axis_in_t           a2_in_r;
  logic [K_W-1:0]     a2_k_r;
  logic signed [57:0] a2_p1_r;
  logic signed [63:0] a2_p2_r;
  logic [31:0]        a2_h_r;
  logic signed [50:0] a2_hacc_r;
  logic signed [57:0] p1_nxt;
  logic signed [63:0] p2_nxt;

  assign p1_nxt = $signed({1'b0, a1_k_r}) * a1_d_r;
  assign p2_nxt = a1_in_r.pos * $signed({1'b0, a1_k2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_valid_r <= 1'b0;
    end else begin
      a2_valid_r <= a1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a2_in_r   <= a1_in_r;
    a2_k_r    <= a1_k_r;
    a2_p1_r   <= p1_nxt;
    a2_p2_r   <= p2_nxt;
    a2_h_r    <= {1'b0, a1_k2_r} + {7'b0, lambda};
    a2_hacc_r <= a1_hacc_r;
  end

  // stage 3: g = 2k(vdes - v) - 2 pos k2, split into sign and magnitude
  logic               a3_valid_r;
  axis_in_t           a3_in_r;
  logic [K_W-1:0]     a3_k_r;
  logic [63:0]        a3_mag_r;
  logic               a3_neg_r;
  logic               a3_zero_r;
  logic [31:0]        a3_h_r;
  logic [49:0]        a3_amag_r;
  logic               a3_aneg_r;
  logic signed [65:0] g_val;
  logic signed [65:0] g_abs;
  logic signed [50:0] hacc_abs;

  assign g_val    = {{7{a2_p1_r[57]}}, a2_p1_r, 1'b0} - {a2_p2_r[63], a2_p2_r, 1'b0};
  assign g_abs    = g_val[65] ? -g_val : g_val;
  assign hacc_abs = a2_hacc_r[50] ? -a2_hacc_r : a2_hacc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a3_valid_r <= 1'b0;
    end else begin
      a3_valid_r <= a2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a3_in_r   <= a2_in_r;
    a3_k_r    <= a2_k_r;
    a3_mag_r  <= g_abs[63:0];
    // -g is negative when g is positive
    a3_neg_r  <= !g_val[65] && (g_val != '0);
    a3_zero_r <= (g_val == '0);
    a3_h_r    <= a2_h_r;
    a3_amag_r <= hacc_abs[49:0];
    a3_aneg_r <= a2_hacc_r[50];
  end

  // quotient divider |g| / H; |hc*acc| / G runs alongside at the same latency
  logic              qd_valid;
  logic [63:0]       qd_quot;
  logic [SIDE_W-1:0] qd_side;
  logic              ad_valid;
  logic [30:0]       ad_quot;
  logic              ad_side;

  lcz_div #(
    .NUM_W  (Q_NUM_W),
    .DEN_W  (32),
    .SIDE_W (SIDE_W),
    .SPS    (DIV_SPS)
  ) u_qdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a3_valid_r),
    .in_num    (a3_mag_r),
    .in_den    (a3_h_r),
    .in_side   ({a3_in_r, a3_k_r, a3_neg_r, a3_zero_r}),
    .out_valid (qd_valid),
    .out_quot  (qd_quot),
    .out_side  (qd_side)
  );

  // |hc*acc| / G by reciprocal multiply on the top 32 bits of the magnitude;
  // the estimate is low by at most two, fixed by compare and subtract, then
  // delayed to line up with the quotient divider
  localparam logic [29:0] G_RECIP = 30'((64'd1 << 49) / 64'(GRAV_Q16));
  localparam logic [48:0] G_ONE   = 49'(GRAV_Q16);
  localparam logic [48:0] G_TWO   = 49'(GRAV_Q16) << 1;
  localparam int unsigned AD_DLY  = Q_DIV_LAT - 3;

  logic        ad1_valid_r;
  logic [61:0] ad1_prod_r;
  logic [48:0] ad1_num_r;
  logic        ad1_neg_r;
  logic        ad2_valid_r;
  logic [29:0] ad2_q_r;
  logic [48:0] ad2_qg_r;
  logic [48:0] ad2_num_r;
  logic        ad2_neg_r;
  logic        ad3_valid_r;
  logic [30:0] ad3_q_r;
  logic        ad3_neg_r;
  logic [61:0] ad_prod_nxt;
  logic [49:0] ad_qg_nxt;
  logic [48:0] ad_rem;
  logic [30:0] ad_q_fix;
  logic        adl_valid_r [AD_DLY];
  logic        adl_neg_r   [AD_DLY];
  logic [30:0] adl_q_r     [AD_DLY];

  assign ad_prod_nxt = {30'b0, a3_amag_r[48:17]} * {32'b0, G_RECIP};
  assign ad_qg_nxt   = {20'b0, ad1_prod_r[61:32]} * {30'b0, GRAV_Q16};
  assign ad_rem      = ad2_num_r - ad2_qg_r;
  assign ad_q_fix    = (ad_rem >= G_TWO) ? {1'b0, ad2_q_r} + 31'd2 :
                       (ad_rem >= G_ONE) ? {1'b0, ad2_q_r} + 31'd1 : {1'b0, ad2_q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad1_valid_r <= 1'b0;
      ad2_valid_r <= 1'b0;
      ad3_valid_r <= 1'b0;
    end else begin
      ad1_valid_r <= a3_valid_r;
      ad2_valid_r <= ad1_valid_r;
      ad3_valid_r <= ad2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ad1_prod_r <= ad_prod_nxt;
    ad1_num_r  <= a3_amag_r[48:0];
    ad1_neg_r  <= a3_aneg_r;
    ad2_q_r    <= ad1_prod_r[61:32];
    ad2_qg_r   <= ad_qg_nxt[48:0];
    ad2_num_r  <= ad1_num_r;
    ad2_neg_r  <= ad1_neg_r;
    ad3_q_r    <= ad_q_fix;
    ad3_neg_r  <= ad2_neg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AD_DLY; i++) adl_valid_r[i] <= 1'b0;
    end else begin
      adl_valid_r[0] <= ad3_valid_r;
      for (int i = 1; i < AD_DLY; i++) adl_valid_r[i] <= adl_valid_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    adl_q_r[0]   <= ad3_q_r;
    adl_neg_r[0] <= ad3_neg_r;
    for (int i = 1; i < AD_DLY; i++) begin
      adl_q_r[i]   <= adl_q_r[i-1];
      adl_neg_r[i] <= adl_neg_r[i-1];
    end
  end

  assign ad_valid = adl_valid_r[AD_DLY-1];
  assign ad_quot  = adl_q_r[AD_DLY-1];
  assign ad_side  = adl_neg_r[AD_DLY-1];

  axis_in_t       qd_in;
  logic [K_W-1:0] qd_k;
  logic           qd_neg;
  logic           qd_zero;

  assign {qd_in, qd_k, qd_neg, qd_zero} = qd_side;

  // stage 4: sign, saturate, clamp to [lo, hi] with hi winning
  logic               a4_valid_r;
  logic signed [31:0] a4_z_r;
  logic signed [31:0] a4_za_r;
  logic signed [31:0] a4_pos_r;
  logic signed [31:0] a4_vel_r;
  logic signed [31:0] a4_lo_r;
  logic signed [31:0] a4_hi_r;
  logic [K_W-1:0]     a4_k_r;
  logic [33:0]        qmag;
  logic signed [34:0] u_val;
  logic signed [34:0] lo_ext;
  logic signed [34:0] hi_ext;
  logic signed [34:0] z_low;
  logic signed [31:0] z_nxt;
  logic signed [63:0] pos64;
  logic signed [63:0] aq64;
  logic signed [63:0] za_sum;

  assign qmag   = (|qd_quot[63:33]) ? 34'h2_0000_0000 : {1'b0, qd_quot[32:0]};
  assign u_val  = qd_zero ? 35'sd0 :
                  (qd_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag}));
  assign lo_ext = {{3{qd_in.lo[31]}}, qd_in.lo};
  assign hi_ext = {{3{qd_in.hi[31]}}, qd_in.hi};
  assign z_low  = (u_val < lo_ext) ? lo_ext : u_val;
  assign z_nxt  = (z_low > hi_ext) ? qd_in.hi : z_low[31:0];
  assign pos64  = {{32{qd_in.pos[31]}}, qd_in.pos};
  assign aq64   = {33'b0, ad_quot};
  assign za_sum = ad_side ? (pos64 + aq64) : (pos64 - aq64);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a4_valid_r <= 1'b0;
    end else begin
      a4_valid_r <= qd_valid;
    end
  end

  always_ff @(posedge clk) begin
    a4_z_r   <= z_nxt;
    a4_za_r  <= sat32(za_sum);
    a4_pos_r <= qd_in.pos;
    a4_vel_r <= qd_in.vel;
    a4_lo_r  <= qd_in.lo;
    a4_hi_r  <= qd_in.hi;
    a4_k_r   <= qd_k;
  end

  // stage 5: k * (pos - zmp)
  logic               a5_valid_r;
  logic signed [57:0] a5_pk_r;
  logic signed [31:0] a5_pos_r;
  logic signed [31:0] a5_vel_r;
  logic signed [31:0] a5_z_r;
  logic signed [31:0] a5_za_r;
  logic signed [32:0] pz_diff;

  assign pz_diff = {a4_pos_r[31], a4_pos_r} - {a4_z_r[31], a4_z_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a5_valid_r <= 1'b0;
    end else begin
      a5_valid_r <= a4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a5_pk_r  <= $signed({1'b0, a4_k_r}) * pz_diff;
    a5_pos_r <= a4_pos_r;
    a5_vel_r <= a4_vel_r;
    a5_z_r   <= a4_z_r;
    a5_za_r  <= a4_za_r;
  end

  // stage 6: stabilized velocity
  logic               a6_valid_r;
  logic signed [31:0] a6_v_r;
  logic signed [31:0] a6_pos_r;
  logic signed [31:0] a6_z_r;
  logic signed [31:0] a6_za_r;
  logic signed [63:0] v_sum;

  assign v_sum = {{32{a5_vel_r[31]}}, a5_vel_r} + {{22{a5_pk_r[57]}}, a5_pk_r[57:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a6_valid_r <= 1'b0;
    end else begin
      a6_valid_r <= a5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a6_v_r   <= sat32(v_sum);
    a6_pos_r <= a5_pos_r;
    a6_z_r   <= a5_z_r;
    a6_za_r  <= a5_za_r;
  end

  // stage 7: T * vel_stable
  logic               a7_valid_r;
  logic signed [48:0] a7_tv_r;
  logic signed [31:0] a7_v_r;
  logic signed [31:0] a7_pos_r;
  logic signed [31:0] a7_z_r;
  logic signed [31:0] a7_za_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a7_valid_r <= 1'b0;
    end else begin
      a7_valid_r <= a6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a7_tv_r  <= $signed({1'b0, period}) * a6_v_r;
    a7_v_r   <= a6_v_r;
    a7_pos_r <= a6_pos_r;
    a7_z_r   <= a6_z_r;
    a7_za_r  <= a6_za_r;
  end

  // stage 8: stabilized position, result register
  logic               a8_valid_r;
  axis_out_t          a8_out_r;
  logic signed [63:0] p_sum;

  assign p_sum = {{32{a7_pos_r[31]}}, a7_pos_r} + {{31{a7_tv_r[48]}}, a7_tv_r[48:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a8_valid_r <= 1'b0;
    end else begin
      a8_valid_r <= a7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a8_out_r.pos_stable <= sat32(p_sum);
    a8_out_r.vel_stable <= a7_v_r;
    a8_out_r.zmp        <= a7_z_r;
    a8_out_r.zmp_actual <= a7_za_r;
  end

  assign out_valid = a8_valid_r;
  assign out_data  = a8_out_r;

  `LCZ_ASSERT(a_div_aligned, qd_valid || ad_valid, qd_valid && ad_valid)
  `LCZ_ASSERT(a_zmp_in_bounds, a4_valid_r && (a4_lo_r <= a4_hi_r),
              (a4_z_r >= a4_lo_r) && (a4_z_r <= a4_hi_r))
  `LCZ_ASSERT(a_zmp_crossed, a4_valid_r && (a4_lo_r > a4_hi_r), a4_z_r == a4_hi_r)
  `LCZ_ASSERT_DLY(a_tail_latency, a4_valid_r, 4, a8_valid_r)

endmodule

@@ rtl/lip_com_zmp_retarget_top.sv @@
// ----------------------------------------------------------------------------
// lip_com_zmp_retarget_top
// LIP CoM retargeting: per-axis bounded one-variable QP for the ZMP, with
// stabilized CoM velocity, position and measured-CoM ZMP.
// ----------------------------------------------------------------------------
// Pipeline: 1 input stage, 9 stages for k = T*G/hc, 24 axis stages
//   including a 16-stage quotient divider.
// Throughput: one transaction per cycle; busy stays low, the pipeline never
//   stalls and the receiver cannot stall it.
// Reset: synchronous active-low rst_n clears valid bits and loads register
//   reset values; data in flight is dropped.
// ----------------------------------------------------------------------------
`include "lip_com_zmp_retarget_top_defines.svh"

module lip_com_zmp_retarget_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vel_target_x,
  input  logic signed [31:0] in_vel_target_y,
  input  logic signed [31:0] in_pos_meas_x,
  input  logic signed [31:0] in_pos_meas_y,
  input  logic signed [31:0] in_vel_meas_x,
  input  logic signed [31:0] in_vel_meas_y,
  input  logic signed [31:0] in_acc_meas_x,
  input  logic signed [31:0] in_acc_meas_y,
  input  logic signed [31:0] in_zmp_low_x,
  input  logic signed [31:0] in_zmp_high_x,
  input  logic signed [31:0] in_zmp_low_y,
  input  logic signed [31:0] in_zmp_high_y,
  output logic               out_valid,
  output logic signed [31:0] out_pos_stable_x,
  output logic signed [31:0] out_pos_stable_y,
  output logic signed [31:0] out_vel_stable_x,
  output logic signed [31:0] out_vel_stable_y,
  output logic signed [31:0] out_zmp_x,
  output logic signed [31:0] out_zmp_y,
  output logic signed [31:0] out_zmp_actual_x,
  output logic signed [31:0] out_zmp_actual_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [24:0]        cfg_wdata
);
  import lcz_pkg::*;

  localparam int unsigned TOTAL_LAT = 1 + K_DIV_LAT + AXIS_LAT;

  logic [PERIOD_W-1:0] period_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [DAMP_W-1:0]   damp_x_r;
  logic [DAMP_W-1:0]   damp_y_r;
  logic [HEIGHT_W-1:0] height_eff;
  logic                accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd655;
      height_r <= 18'd39322;
      damp_x_r <= 25'd65536;
      damp_y_r <= 25'd65536;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        CFG_DAMP_X: damp_x_r <= cfg_wdata[DAMP_W-1:0];
        CFG_DAMP_Y: damp_y_r <= cfg_wdata[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign height_eff = (height_r < HC_MIN) ? HC_MIN : height_r;
  assign busy       = 1'b0;
  assign accept     = start && !busy;

  // input stage: capture transaction, form T*G
  logic               s0_valid_r;
  logic [K_NUM_W-1:0] s0_tg_r;
  axis_in_t           s0_x_r;
  axis_in_t           s0_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_tg_r <= {20'b0, period_r} * {16'b0, GRAV_Q16};
    s0_x_r  <= '{vdes: in_vel_target_x, pos: in_pos_meas_x, vel: in_vel_meas_x,
                 acc: in_acc_meas_x, lo: in_zmp_low_x, hi: in_zmp_high_x};
    s0_y_r  <= '{vdes: in_vel_target_y, pos: in_pos_meas_y, vel: in_vel_meas_y,
                 acc: in_acc_meas_y, lo: in_zmp_low_y, hi: in_zmp_high_y};
  end

  // k = floor(T*G / hc), shared by both axes
  logic                       kd_valid;
  logic [K_NUM_W-1:0]         kd_quot;
  logic [2*$bits(axis_in_t)-1:0] kd_side;
  axis_in_t                   kd_x;
  axis_in_t                   kd_y;

  lcz_div #(
    .NUM_W  (K_NUM_W),
    .DEN_W  (HEIGHT_W),
    .SIDE_W (2 * $bits(axis_in_t)),
    .SPS    (DIV_SPS)
  ) u_kdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_num    (s0_tg_r),
    .in_den    (height_eff),
    .in_side   ({s0_x_r, s0_y_r}),
    .out_valid (kd_valid),
    .out_quot  (kd_quot),
    .out_side  (kd_side)
  );

  assign {kd_x, kd_y} = kd_side;

  logic      ax_valid;
  logic      ay_valid;
  axis_out_t ax_out;
  axis_out_t ay_out;

  lcz_axis u_axis_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (kd_valid),
    .in_k      (kd_quot[K_W-1:0]),
    .in_data   (kd_x),
    .lambda    (damp_x_r),
    .period    (period_r),
    .height    (height_eff),
    .out_valid (ax_valid),
    .out_data  (ax_out)
  );

  lcz_axis u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (kd_valid),
    .in_k      (kd_quot[K_W-1:0]),
    .in_data   (kd_y),
    .lambda    (damp_y_r),
    .period    (period_r),
    .height    (height_eff),
    .out_valid (ay_valid),
    .out_data  (ay_out)
  );

  assign out_valid        = ax_valid;
  assign out_pos_stable_x = ax_out.pos_stable;
  assign out_pos_stable_y = ay_out.pos_stable;
  assign out_vel_stable_x = ax_out.vel_stable;
  assign out_vel_stable_y = ay_out.vel_stable;
  assign out_zmp_x        = ax_out.zmp;
  assign out_zmp_y        = ay_out.zmp;
  assign out_zmp_actual_x = ax_out.zmp_actual;
  assign out_zmp_actual_y = ay_out.zmp_actual;

  `LCZ_ASSERT(a_axes_aligned, ax_valid || ay_valid, ax_valid && ay_valid)
  `LCZ_ASSERT_DLY(a_fwd_latency, accept, TOTAL_LAT, out_valid)
  `LCZ_ASSERT(a_k_valid_src, kd_valid, $past(s0_valid_r, K_DIV_LAT))

endmodule
